[sv/morse_character_encoder_macros.svh]
// Assertion macros shared by the encoder RTL.
`ifndef MORSE_CHARACTER_ENCODER_MACROS_SVH
`define MORSE_CHARACTER_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/mce_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mce_pkg;

	localparam int REG_COUNT = 5;

	typedef enum logic [2:0] {
		REG_DOT,
		REG_DASH,
		REG_ELEM,
		REG_LETTER,
		REG_WORD
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_PUSH
	} state_t;

	typedef enum logic [2:0] {
		SEG_ON,
		SEG_GAP,
		SEG_LETTER,
		SEG_WORD,
		SEG_UNSUP
	} seg_t;

	function automatic logic [15:0] cfg_reset_value(input logic [2:0] idx);
		logic [15:0] v;
		unique case (idx)
			REG_DOT:    v = 16'd200;
			REG_DASH:   v = 16'd600;
			REG_ELEM:   v = 16'd200;
			REG_LETTER: v = 16'd600;
			REG_WORD:   v = 16'd1400;
			default:    v = 16'd0;
		endcase
		return v;
	endfunction

	// Code layout: element count in bits 7..5, elements in bits 4..0 with the
	// first element at bit count-1; a one is a dash.
	function automatic logic [7:0] letter_code(input logic [4:0] idx);
		logic [7:0] c;
		unique case (idx)
			5'd0:    c = {3'd2, 5'd1};
			5'd1:    c = {3'd4, 5'd8};
			5'd2:    c = {3'd4, 5'd10};
			5'd3:    c = {3'd3, 5'd4};
			5'd4:    c = {3'd1, 5'd0};
			5'd5:    c = {3'd4, 5'd2};
			5'd6:    c = {3'd3, 5'd6};
			5'd7:    c = {3'd4, 5'd0};
			5'd8:    c = {3'd2, 5'd0};
			5'd9:    c = {3'd4, 5'd7};
			5'd10:   c = {3'd3, 5'd5};
			5'd11:   c = {3'd4, 5'd4};
			5'd12:   c = {3'd2, 5'd3};
			5'd13:   c = {3'd2, 5'd2};
			5'd14:   c = {3'd3, 5'd7};
			5'd15:   c = {3'd4, 5'd6};
			5'd16:   c = {3'd4, 5'd13};
			5'd17:   c = {3'd3, 5'd2};
			5'd18:   c = {3'd3, 5'd0};
			5'd19:   c = {3'd1, 5'd1};
			5'd20:   c = {3'd3, 5'd1};
			5'd21:   c = {3'd4, 5'd1};
			5'd22:   c = {3'd3, 5'd3};
			5'd23:   c = {3'd4, 5'd9};
			5'd24:   c = {3'd4, 5'd11};
			5'd25:   c = {3'd4, 5'd12};
			default: c = 8'd0;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] digit_code(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:    c = {3'd5, 5'd31};
			4'd1:    c = {3'd5, 5'd15};
			4'd2:    c = {3'd5, 5'd7};
			4'd3:    c = {3'd5, 5'd3};
			4'd4:    c = {3'd5, 5'd1};
			4'd5:    c = {3'd5, 5'd0};
			4'd6:    c = {3'd5, 5'd16};
			4'd7:    c = {3'd5, 5'd24};
			4'd8:    c = {3'd5, 5'd28};
			4'd9:    c = {3'd5, 5'd30};
			default: c = 8'd0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[sv/morse_character_encoder.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "morse_character_encoder_macros.svh"

// International Morse encoder for A-Z, a-z, 0-9 and space. Each accepted
// character byte yields its keying segments on the master stream, one
// transaction per segment, with tlast on the last segment of the character.
// The five timing registers sit in a small configuration memory with a single
// registered read port, and every segment but an unsupported one is built from
// it: an on or element gap segment takes a read, then output, a gap difference
// segment takes two reads, then output, and each character is first taken in
// the idle state. Configuration writes are taken at any time and must only be
// issued while the encoder is idle.
module morse_character_encoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [0] lamp_on, [16:1] span_ticks, [23:17] zero
	output logic             m_tuser,   // [0] unsupported
	output logic             m_tlast,   // final_segment
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import mce_pkg::*;

	logic [15:0]          cfg_mem [0:REG_COUNT-1];
	logic [REG_COUNT-1:0] cfg_vld_q;

	state_t      state_q, state_d;
	seg_t        seg_q;
	logic [2:0]  cnt_q;
	logic [4:0]  bits_q;
	logic [15:0] a_q;

	logic        rd_en;
	logic [2:0]  rd_addr;
	logic [15:0] rd_data_q;
	logic        rd_hit_q;
	logic [2:0]  rd_addr_q;
	logic [15:0] rd_value;

	logic        s_accept;
	logic        out_free;
	logic        push;
	logic        seg_done;
	logic [15:0] span;

	logic [7:0]  ch_fold;
	logic [7:0]  ch_code;
	seg_t        ch_seg;
	logic [2:0]  ch_n;
	logic [4:0]  ch_bits;

	logic        m_tvalid_q;
	logic        lamp_q;
	logic [15:0] span_q;
	logic        unsup_q;
	logic        final_q;

	assign cfg_ready = 1'b1;
	assign s_accept  = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_vld_q <= '0;
		end else if (cfg_valid && cfg_index <= REG_WORD) begin
			cfg_vld_q[cfg_index] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_valid && cfg_index <= REG_WORD) begin
			cfg_mem[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= cfg_mem[rd_addr];
			rd_hit_q  <= cfg_vld_q[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	assign rd_value = rd_hit_q ? rd_data_q : cfg_reset_value(rd_addr_q);

	always_comb begin
		ch_fold = s_tdata;
		if (s_tdata >= 8'h61 && s_tdata <= 8'h7A) begin
			ch_fold = s_tdata - 8'h20;
		end
		ch_code = 8'd0;
		ch_seg  = SEG_UNSUP;
		priority if (ch_fold == 8'h20) begin
			ch_seg = SEG_WORD;
		end else if (ch_fold >= 8'h41 && ch_fold <= 8'h5A) begin
			ch_code = letter_code(5'(ch_fold - 8'h41));
			ch_seg  = SEG_ON;
		end else if (ch_fold >= 8'h30 && ch_fold <= 8'h39) begin
			ch_code = digit_code(4'(ch_fold - 8'h30));
			ch_seg  = SEG_ON;
		end else begin
			ch_seg = SEG_UNSUP;
		end
		ch_n    = ch_code[7:5];
		ch_bits = ch_code[4:0] << (3'd5 - ch_n);
	end

	always_comb begin
		seg_done = (seg_q == SEG_LETTER) || (seg_q == SEG_UNSUP);
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					state_d = (ch_seg == SEG_UNSUP) ? ST_PUSH : ST_RD_A;
				end
			end
			ST_RD_A: begin
				state_d = (seg_q == SEG_LETTER || seg_q == SEG_WORD) ? ST_RD_B : ST_PUSH;
			end
			ST_RD_B: begin
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (out_free) begin
					state_d = seg_done ? ST_IDLE : ST_RD_A;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		rd_en    = (state_q == ST_RD_A) || (state_q == ST_RD_B);
		push     = (state_q == ST_PUSH) && out_free;
		rd_addr  = REG_DOT;
		if (state_q == ST_RD_B) begin
			rd_addr = (seg_q == SEG_WORD) ? REG_LETTER : REG_ELEM;
		end else begin
			unique case (seg_q)
				SEG_ON:     rd_addr = bits_q[4] ? REG_DASH : REG_DOT;
				SEG_GAP:    rd_addr = REG_ELEM;
				SEG_LETTER: rd_addr = REG_LETTER;
				SEG_WORD:   rd_addr = REG_WORD;
				SEG_UNSUP:  rd_addr = REG_DOT;
				default:    rd_addr = REG_DOT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seg_q   <= SEG_UNSUP;
		end else begin
			state_q <= state_d;
			if (s_accept) begin
				seg_q <= ch_seg;
			end else if (push) begin
				unique case (seg_q)
					SEG_ON:     seg_q <= SEG_GAP;
					SEG_GAP:    seg_q <= (cnt_q == 3'd1) ? SEG_LETTER : SEG_ON;
					SEG_WORD:   seg_q <= SEG_LETTER;
					SEG_LETTER: seg_q <= SEG_LETTER;
					SEG_UNSUP:  seg_q <= SEG_UNSUP;
					default:    seg_q <= SEG_UNSUP;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cnt_q  <= ch_n;
			bits_q <= ch_bits;
		end else if (push && seg_q == SEG_GAP) begin
			cnt_q  <= cnt_q - 3'd1;
			bits_q <= {bits_q[3:0], 1'b0};
		end
		if (state_q == ST_RD_B) begin
			a_q <= rd_value;
		end
	end

	always_comb begin
		unique case (seg_q)
			SEG_LETTER, SEG_WORD: span = (a_q > rd_value) ? (a_q - rd_value) : 16'd0;
			SEG_UNSUP:            span = 16'd0;
			default:              span = rd_value;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			lamp_q  <= (seg_q == SEG_ON);
			span_q  <= span;
			unsup_q <= (seg_q == SEG_UNSUP);
			final_q <= seg_done;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, span_q, lamp_q};
	assign m_tuser  = unsup_q;
	assign m_tlast  = final_q;

	`MCE_ASSERT_NEXT(a_push_loads_output, push, m_tvalid, "segment push did not reach output")
	`MCE_ASSERT_NEXT(a_accept_leaves_idle, s_accept, !s_tready, "encoder idle after taking a character")
	`MCE_ASSERT_SAME(a_unsup_single, m_tvalid && m_tuser, m_tlast && m_tdata[16:1] == 16'd0,
		"unsupported segment is not a single empty final segment")
	`MCE_ASSERT_SAME(a_on_not_final, m_tvalid && m_tdata[0], !m_tlast && !m_tuser,
		"keyed-on segment marked final or unsupported")

endmodule

`default_nettype wire
